@@ src/srs_pkg.sv @@
// Shared constants and types for the systematic resampler.
`default_nettype none

package srs_pkg;

    localparam int MAX_PARTICLES = 64;
    localparam int WEIGHT_BITS   = 16;

    // Widths of the interface fields and of the internal arithmetic.
    localparam int IDX_W  = $clog2(MAX_PARTICLES);
    localparam int CNT_W  = IDX_W + 1;
    localparam int FLD_W  = 16;
    localparam int SUM_W  = WEIGHT_BITS + IDX_W;
    localparam int LHS_W  = SUM_W + CNT_W;
    localparam int THR_W  = LHS_W + FLD_W;

    localparam logic [FLD_W-1:0] WEIGHT_MASK =
        FLD_W'((64'd1 << WEIGHT_BITS) - 64'd1);

    localparam logic [CNT_W-1:0] COUNT_MAX   = CNT_W'(MAX_PARTICLES);
    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(64);

    // Word kinds carried on the input tuser.
    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_RESAMPLE = 1'b1;

    // Write request towards the prefix-sum memory.
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        logic [SUM_W-1:0] data;
    } t_ram_wr;

endpackage

`default_nettype wire

@@ src/srs_prefix_ram.sv @@
// Prefix-sum memory: one write port and one registered read port.
`default_nettype none

module srs_prefix_ram (
    input  wire                          i_clk,
    input  wire  srs_pkg::t_ram_wr       i_wr,
    input  wire  [srs_pkg::IDX_W-1:0]    i_rd_addr,
    output logic [srs_pkg::SUM_W-1:0]    o_rd_data
);
    import srs_pkg::*;

    logic [SUM_W-1:0] r_mem [MAX_PARTICLES];

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

@@ src/systematic_resampler.sv @@
// Top level of the systematic resampler: load sequencer, draw walk and output register.
//
// Usage. Words arrive on s_axis. A word whose tuser is 0 loads one weight (tdata[15:0]);
// the block stores the running inclusive prefix sum and keeps the total. Loads are
// taken one per cycle while the block is idle, and loads beyond the particle count
// are dropped silently. A word whose tuser is 1 starts a resampling round with the
// random fraction in tdata[31:16]; one m_axis word follows per draw (source index,
// target index, tlast on the final draw), after which the loaded weights are
// cleared. The particle count is written through i_cfg_we / i_cfg_data while idle;
// zero acts as one and values above the maximum act as the maximum.
// Sequence. A resample word passes the set-up states (total look-up, threshold product
// and the scaling product of source 0); each advance of the source pointer then passes
// memory read, scaling product and compare, and each draw is emitted from the compare
// state. The input stays not ready until the round's last draw has been emitted.
// Stalls. Results sit in an output register; while the receiver holds tready low the
// walk waits at its compare step and no result is lost. Loads may be taken while the
// last result of a round still waits to be collected.
// Reset. The synchronous active-low reset empties the block, drops any pending result
// and sets the particle count to 64. The memory is not cleared; only entries written
// in the current round are read.
`default_nettype none

module systematic_resampler (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Configuration: particle count.
    input  wire         i_cfg_we,
    input  wire  [6:0]  i_cfg_data,
    // Input words.
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // [15:0] weight, [31:16] random_fraction
    input  wire         s_axis_tuser,   // [0] opcode
    // Result words.
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [5:0] source_index, [11:6] target_index
    output logic        m_axis_tlast
);
    import srs_pkg::*;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_TOT  = 3'd1;  // pick the round total
    localparam logic [2:0] ST_TMUL = 3'd2;  // first threshold product
    localparam logic [2:0] ST_RD   = 3'd3;  // wait for prefix sum of source
    localparam logic [2:0] ST_MUL  = 3'd4;  // scale cumulative weight by N
    localparam logic [2:0] ST_CMP  = 3'd5;  // compare and emit

    logic [2:0]       r_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_loaded;
    logic [SUM_W-1:0] r_wtot;

    // Walk registers.
    logic [SUM_W-1:0] r_total;
    logic [FLD_W-1:0] r_frac;
    logic [IDX_W-1:0] r_src;
    logic [IDX_W-1:0] r_k;
    logic [LHS_W-1:0] r_lhs;
    logic [THR_W-1:0] r_thr;

    // Output register.
    logic             r_out_valid;
    logic [IDX_W-1:0] r_out_src;
    logic [IDX_W-1:0] r_out_tgt;
    logic             r_out_last;

    logic [CNT_W-1:0] n_eff;
    logic [IDX_W-1:0] n_m1;
    logic             in_acc;
    logic             is_load;
    logic             is_resample;
    logic [FLD_W-1:0] weight_in;
    logic [SUM_W-1:0] sum_next;
    logic             load_ok;
    t_ram_wr          ram_wr;
    logic [IDX_W-1:0] rd_addr;
    logic [SUM_W-1:0] rd_data;
    logic [SUM_W-1:0] cum;
    logic             qualifies;
    logic             out_free;
    logic             emit;
    logic             emit_last;

    // Effective particle count: zero acts as one, above maximum is clamped.
    always_comb begin
        if (r_count == '0) begin
            n_eff = CNT_W'(1);
        end else if (r_count > COUNT_MAX) begin
            n_eff = COUNT_MAX;
        end else begin
            n_eff = r_count;
        end
    end
    assign n_m1 = IDX_W'(n_eff - CNT_W'(1));

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign is_load       = in_acc && (s_axis_tuser == OP_LOAD);
    assign is_resample   = in_acc && (s_axis_tuser == OP_RESAMPLE);

    assign weight_in = s_axis_tdata[FLD_W-1:0] & WEIGHT_MASK;
    assign sum_next  = r_wtot + SUM_W'(weight_in);
    assign load_ok   = is_load && (r_loaded < n_eff);

    always_comb begin
        ram_wr.we   = load_ok;
        ram_wr.addr = r_loaded[IDX_W-1:0];
        ram_wr.data = sum_next;
    end

    // While idle the read port looks up source N-1 for the round total.
    assign rd_addr = (r_state == ST_IDLE) ? n_m1 : r_src;

    srs_prefix_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (ram_wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Sources not loaded this round read as the running total.
    assign cum = ({1'b0, r_src} < r_loaded) ? rd_data : r_wtot;

    // cum * N * 65536 >= total * (k * 65536 + r); the last source always qualifies.
    assign qualifies = ({r_lhs, FLD_W'(0)} >= r_thr) || (r_src == n_m1);
    assign out_free  = !r_out_valid || m_axis_tready;
    assign emit      = (r_state == ST_CMP) && qualifies && out_free;
    assign emit_last = emit && (r_k == n_m1);

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= COUNT_RESET;
            r_loaded    <= '0;
            r_wtot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_count <= i_cfg_data;
            end
            if (load_ok) begin
                r_loaded <= r_loaded + CNT_W'(1);
                r_wtot   <= sum_next;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (is_resample) begin
                        r_state <= ST_TOT;
                    end
                end
                ST_TOT:  r_state <= ST_TMUL;
                ST_TMUL: r_state <= ST_MUL;
                ST_RD:   r_state <= ST_MUL;
                ST_MUL:  r_state <= ST_CMP;
                ST_CMP: begin
                    if (emit_last) begin
                        r_state  <= ST_IDLE;
                        r_loaded <= '0;
                        r_wtot   <= '0;
                    end else if (!qualifies) begin
                        r_state <= ST_RD;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Walk datapath and output payload.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_frac <= s_axis_tdata[2*FLD_W-1:FLD_W];
                r_src  <= '0;
                r_k    <= '0;
            end
            ST_TOT: begin
                r_total <= (n_m1 < r_loaded[IDX_W-1:0] || r_loaded > COUNT_MAX - CNT_W'(1))
                           ? rd_data : r_wtot;
            end
            ST_TMUL: begin
                r_thr <= THR_W'(r_total * r_frac);
            end
            ST_MUL: begin
                r_lhs <= LHS_W'(cum * n_eff);
            end
            ST_CMP: begin
                if (emit) begin
                    r_thr <= r_thr + THR_W'({r_total, FLD_W'(0)});
                    r_k   <= r_k + IDX_W'(1);
                end else if (!qualifies) begin
                    r_src <= r_src + IDX_W'(1);
                end
            end
            default: begin
            end
        endcase
        if (emit) begin
            r_out_src  <= r_src;
            r_out_tgt  <= r_k;
            r_out_last <= (r_k == n_m1);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out_tgt, r_out_src};
    assign m_axis_tlast  = r_out_last;

    // The source pointer never runs past the last source of the round.
    a_src_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE && r_state != ST_TOT) |-> (r_src <= n_m1))
        else $error("source pointer beyond last particle");

    // Finishing a round empties the loaded weights.
    a_round_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_last |=> (r_loaded == '0 && r_wtot == '0 && r_state == ST_IDLE))
        else $error("round end did not clear the loaded weights");

    // A result marked last carries the final target slot.
    a_last_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[2*IDX_W-1:IDX_W] == n_m1))
        else $error("last flag on a slot other than the final one");

    // The loaded count never exceeds the memory depth.
    a_loaded_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_ok |=> (r_loaded <= COUNT_MAX))
        else $error("loaded count beyond memory depth");

endmodule

`default_nettype wire

@@ tb/sv/systematic_resampler_checker.sv @@
// Checker for the systematic resampler: tracks the weight store and predicts each round.
module systematic_resampler_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [6:0]  i_cfg_data,
    input  wire         i_word_valid,
    input  wire         i_word_ready,
    input  wire  [31:0] i_word_data,
    input  wire         i_word_user,
    input  wire         i_draw_valid,
    input  wire         i_draw_ready,
    input  wire  [15:0] i_draw_data,
    input  wire         i_draw_last,
    output int          o_fail_count,
    output int          o_pending
);
    import srs_pkg::*;

    localparam longint unsigned FRAC_ONE = 65536;

    typedef struct packed {
        logic [IDX_W-1:0] source;
        logic [IDX_W-1:0] target;
        logic             last;
    } t_draw;

    logic [SUM_W-1:0] prefix_sums [MAX_PARTICLES];
    logic [SUM_W-1:0] weight_sum;
    logic [CNT_W-1:0] loaded;
    logic [6:0]       count_reg;
    t_draw            expected_draws [$];
    int               fails = 0;

    assign o_fail_count = fails;

    // A count of zero behaves as one and anything above the store depth as the depth.
    function automatic longint unsigned active_count();
        if (count_reg == 7'd0) return 1;
        if (count_reg > MAX_PARTICLES) return MAX_PARTICLES;
        return count_reg;
    endfunction

    // Sources that were not loaded this round carry the running total.
    function automatic longint unsigned cumulative(input longint unsigned s);
        if (s < loaded) return prefix_sums[s];
        return weight_sum;
    endfunction

    function automatic void load_weight(input logic [15:0] w);
        if (loaded < active_count()) begin
            weight_sum           = weight_sum + SUM_W'(w & WEIGHT_MASK);
            prefix_sums[loaded]  = weight_sum;
            loaded               = loaded + 1'b1;
        end
    endfunction

    function automatic void predict_draws(input logic [15:0] frac);
        longint unsigned n;
        longint unsigned total;
        longint unsigned thr;
        longint unsigned src;
        longint unsigned k;
        t_draw           d;
        n     = active_count();
        total = cumulative(n - 1);
        src   = 0;
        for (k = 0; k < n; k++) begin
            thr = total * (k * FRAC_ONE + frac);
            while (src < n - 1 && cumulative(src) * n * FRAC_ONE < thr) src++;
            d.source = src[IDX_W-1:0];
            d.target = k[IDX_W-1:0];
            d.last   = (k == n - 1);
            expected_draws.push_back(d);
        end
        loaded     = '0;
        weight_sum = '0;
    endfunction

    always @(posedge i_clk) begin : watch
        t_draw got;
        t_draw want;
        if (!i_rst_n) begin
            count_reg  = COUNT_RESET;
            loaded     = '0;
            weight_sum = '0;
            expected_draws.delete();
        end else begin
            if (i_cfg_we) count_reg = i_cfg_data;
            if (i_word_valid && i_word_ready) begin
                if (i_word_user == OP_RESAMPLE) predict_draws(i_word_data[31:16]);
                else load_weight(i_word_data[15:0]);
            end
            if (i_draw_valid && i_draw_ready) begin
                got.source = i_draw_data[IDX_W-1:0];
                got.target = i_draw_data[2*IDX_W-1:IDX_W];
                got.last   = i_draw_last;
                if (expected_draws.size() == 0) begin
                    $display("%0t: unexpected draw, expected none,", $time,
                             " got src %0d tgt %0d last %0d",
                             got.source, got.target, got.last);
                    fails++;
                end else begin
                    want = expected_draws.pop_front();
                    if (got.source != want.source || got.target != want.target ||
                        got.last != want.last) begin
                        $display("%0t: draw mismatch,", $time,
                                 " expected src %0d tgt %0d last %0d,",
                                 want.source, want.target, want.last,
                                 " got src %0d tgt %0d last %0d",
                                 got.source, got.target, got.last);
                        fails++;
                    end
                end
            end
        end
        o_pending <= expected_draws.size();
    end

endmodule

@@ tb/sv/systematic_resampler_tb.sv @@
// Testbench top for the systematic resampler: clock, reset, word stimulus and the verdict.
module systematic_resampler_tb;

    import srs_pkg::*;

    // Cycles of quiet before a count write and at the end of the run; a round
    // finishes clearing its weights when its last draw is emitted, before it is taken.
    localparam int QUIET_CYCLES = 32;
    // Length of the one long hold-off on the result side.
    localparam int LONG_HOLD    = 300;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [6:0]  i_cfg_data    = 7'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = 32'd0;   // [15:0] weight, [31:16] random_fraction
    logic        s_axis_tuser  = 1'b0;    // [0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;            // [5:0] source_index, [11:6] target_index
    logic        m_axis_tlast;

    int   fail_count;
    int   pending;
    int   tx_idle_pct  = 13;
    int   rx_idle_pct  = 78;
    int   cur_count    = 64;
    int   random_items = 0;
    logic hold_go      = 1'b0;
    int   hold_cycles  = 0;

    systematic_resampler dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    systematic_resampler_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_word_valid (s_axis_tvalid),
        .i_word_ready (s_axis_tready),
        .i_word_data  (s_axis_tdata),
        .i_word_user  (s_axis_tuser),
        .i_draw_valid (m_axis_tvalid),
        .i_draw_ready (m_axis_tready),
        .i_draw_data  (m_axis_tdata),
        .i_draw_last  (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // The result side. It stalls at random at the current rate, except for one
    // long hold-off, counted here, which starts once the stimulus raises hold_go.
    always @(posedge i_clk) begin
        if (hold_go && hold_cycles < LONG_HOLD) begin
            m_axis_tready <= 1'b0;
            hold_cycles   <= hold_cycles + 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // The run is cut short if the block hangs.
    initial begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

    // Offers one word, with random idle cycles ahead of it, and returns at the
    // clock edge at which it is taken.
    task automatic send_word(input logic op, input logic [15:0] weight,
                             input logic [15:0] fraction);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {fraction, weight};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Waits until every predicted draw has been collected, then lets the block
    // settle. The first edge lets the checker count a word taken just now.
    task automatic wait_quiet();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    // The particle count is only changed while the block is idle.
    task automatic write_count(input logic [6:0] value);
        s_axis_tvalid <= 1'b0;
        wait_quiet();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_count  = value;
    endtask

    function automatic int draws_per_round(input int count);
        if (count == 0) return 1;
        if (count > MAX_PARTICLES) return MAX_PARTICLES;
        return count;
    endfunction

    // Weights lean towards zero, tiny values and the full-scale value, since
    // those are where the compare and the zero-total path are most delicate.
    function automatic logic [15:0] next_weight();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10) return 16'h0000;
        if (pick < 20) return 16'hFFFF;
        if (pick < 40) return 16'($urandom_range(15));
        return 16'($urandom);
    endfunction

    // One random round. Most rounds load exactly N weights; the rest are short
    // rounds, rounds with surplus loads that the block drops, and long rounds
    // in which the count shrinks after loading.
    task automatic random_round();
        int pick;
        int n;
        int n_loads;
        int kind;
        if (random_items < 50) begin
            tx_idle_pct = 13;
            rx_idle_pct <= 78;
        end else if (random_items < 100) begin
            tx_idle_pct = 78;
            rx_idle_pct <= 13;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct <= 0;
        end
        if ($urandom_range(1) == 1) begin
            pick = $urandom_range(99);
            if (pick < 60)      write_count(7'($urandom_range(8, 1)));
            else if (pick < 85) write_count(7'($urandom_range(32, 9)));
            else if (pick < 95) write_count(7'($urandom_range(64, 33)));
            else if (pick < 98) write_count(7'($urandom_range(127, 65)));
            else                write_count(7'd0);
        end
        n    = draws_per_round(cur_count);
        kind = $urandom_range(99);
        if (kind < 70)      n_loads = n;
        else if (kind < 82) n_loads = $urandom_range(n - 1, 0);
        else if (kind < 92) n_loads = n + $urandom_range(3, 1);
        else                n_loads = n;
        repeat (n_loads) send_word(OP_LOAD, next_weight(), 16'($urandom));
        if (kind >= 92 && n > 1) write_count(7'($urandom_range(n - 1, 1)));
        send_word(OP_RESAMPLE, 16'($urandom), 16'($urandom));
        random_items += ((n_loads < n) ? n_loads : n) + 1;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. The first round runs at the count left by reset with
        // nothing loaded, so the total is zero and every draw takes source 0,
        // here with the largest random fraction.
        send_word(OP_RESAMPLE, 16'($urandom), 16'hFFFF);

        // Four particles with extreme weights and the smallest fraction.
        write_count(7'd4);
        send_word(OP_LOAD, 16'hFFFF, 16'($urandom));
        send_word(OP_LOAD, 16'h0000, 16'($urandom));
        send_word(OP_LOAD, 16'h0001, 16'($urandom));
        send_word(OP_LOAD, 16'h8000, 16'($urandom));
        send_word(OP_RESAMPLE, 16'($urandom), 16'h0000);

        // A short round: the unloaded sources stand at the running total.
        send_word(OP_LOAD, 16'h1234, 16'($urandom));
        send_word(OP_LOAD, 16'hEDCB, 16'($urandom));
        send_word(OP_RESAMPLE, 16'($urandom), 16'h8000);

        // Surplus loads are dropped; then the count shrinks to two before the
        // resample word, so only the first two sources take part.
        repeat (6) send_word(OP_LOAD, next_weight(), 16'($urandom));
        write_count(7'd2);
        send_word(OP_RESAMPLE, 16'($urandom), 16'($urandom));

        // A count of zero acts as a single particle.
        write_count(7'd0);
        send_word(OP_LOAD, 16'hFFFF, 16'($urandom));
        send_word(OP_RESAMPLE, 16'($urandom), 16'hFFFF);

        // A count above the depth acts as the full depth; three loads only.
        write_count(7'd127);
        send_word(OP_LOAD, 16'hFFFF, 16'($urandom));
        send_word(OP_LOAD, 16'hFFFF, 16'($urandom));
        send_word(OP_LOAD, 16'h0000, 16'($urandom));
        send_word(OP_RESAMPLE, 16'($urandom), 16'($urandom));

        // Random part. It opens with a full round of 64 during which the
        // result side holds off for a long stretch; the sender carries on with
        // the next round, so the output fills and the input is stalled.
        write_count(7'd64);
        repeat (64) send_word(OP_LOAD, next_weight(), 16'($urandom));
        hold_go <= 1'b1;
        send_word(OP_RESAMPLE, 16'($urandom), 16'($urandom));
        repeat (8) send_word(OP_LOAD, next_weight(), 16'($urandom));
        send_word(OP_RESAMPLE, 16'($urandom), 16'($urandom));
        random_items = 74;

        // The sender pauses here until every draw so far has been collected.
        s_axis_tvalid <= 1'b0;
        wait_quiet();

        while (random_items < 150) random_round();

        s_axis_tvalid <= 1'b0;
        wait_quiet();
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/srs_pkg.sv
src/srs_prefix_ram.sv
src/systematic_resampler.sv
tb/sv/systematic_resampler_checker.sv
tb/sv/systematic_resampler_tb.sv
